// File: hw/rtl/tcfo_pkg.sv
`timescale 1ns / 1ps

package tcfo_pkg;

    // Command codes carried in the low bits of the input tuser
    localparam logic [1:0] CMD_ENQ     = 2'd0;
    localparam logic [1:0] CMD_DEQ_ANY = 2'd1;
    localparam logic [1:0] CMD_DEQ_C0  = 2'd2;
    localparam logic [1:0] CMD_DEQ_C1  = 2'd3;

    // Status codes returned with every result
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Queue request from the top level
    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    // Queue condition back to the top level
    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    // Per-cell controls inside a queue
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

// File: hw/rtl/tcfo_cell.sv
`timescale 1ns / 1ps

module tcfo_cell #(
    parameter int W = 16
) (
    input  logic                  clk,
    input  tcfo_pkg::cell_ctrl_t  ctrl,
    input  logic [W-1:0]          load_data,
    input  logic [W-1:0]          upstream_data,
    output logic [W-1:0]          data
);

    logic [W-1:0] data_reg;
    logic [W-1:0] data_next;

    // Shift toward the head on a pop, take the new stamp on a push
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift)
        begin
            data_next = upstream_data;
        end
        else if (ctrl.load)
        begin
            data_next = load_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: hw/rtl/tcfo_queue.sv
`timescale 1ns / 1ps

module tcfo_queue #(
    parameter int DEPTH = 16,
    parameter int W     = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcfo_pkg::q_ctrl_t    ctrl,
    input  logic [W-1:0]         push_data,
    output tcfo_pkg::q_stat_t    stat,
    output logic [W-1:0]         head_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [W-1:0]     cell_data [DEPTH];

    // Cell 0 is the head; the first free cell sits at position count
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            tcfo_pkg::cell_ctrl_t cc;
            logic [W-1:0]         up;

            assign cc.shift = ctrl.pop;
            assign cc.load  = ctrl.push && (count_reg == CNT_W'(i));
            if (i == DEPTH - 1)
            begin : g_last
                assign up = '0;
            end
            else
            begin : g_mid
                assign up = cell_data[i + 1];
            end

            tcfo_cell #(.W(W)) u_cell (
                .clk           (clk),
                .ctrl          (cc),
                .load_data     (push_data),
                .upstream_data (up),
                .data          (cell_data[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign head_data  = cell_data[0];

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.push && stat.full))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.pop && stat.empty))
        else $error("pop from empty queue");

    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.push && ctrl.pop))
        else $error("push and pop in one cycle");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("count did not advance on push");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("count beyond depth");

endmodule

// File: hw/rtl/two_class_fifo_oldest_first_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: cmd[1:0], item_class[2]; tdata: stamp
// m_*       out  m_tvalid/m_tready  tuser: status[1:0], out_class[2]; tdata: out_stamp
//
// One transfer in gives one transfer out through the result register, valid in the cycle after the accept.
// One item per cycle while m_tready does not stall: each queue is a chain of stamp cells with the head at cell 0,
// so a pop shifts every cell one step and the head compare is a single STAMP_WIDTH compare.
// rst_n clears both fill counts and the result valid; stamp cells need no reset.
// A new item is taken while the result register is empty or being drained in the
// same cycle; a stalled m_tready holds the result and blocks s_tready.
module two_class_fifo_oldest_first_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int STAMP_WIDTH = 16,
    localparam int TDATA_W    = ((STAMP_WIDTH + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // stamp, zero padded
    input  logic [2:0]         s_tuser,   // cmd[1:0], item_class[2]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // out_stamp, zero padded
    output logic [2:0]         m_tuser    // status[1:0], out_class[2]
);

    logic [1:0]             cmd;
    logic                   item_class;
    logic [STAMP_WIDTH-1:0] stamp;
    logic                   accept;

    tcfo_pkg::q_ctrl_t      q0_ctrl;
    tcfo_pkg::q_ctrl_t      q1_ctrl;
    tcfo_pkg::q_stat_t      q0_stat;
    tcfo_pkg::q_stat_t      q1_stat;
    logic [STAMP_WIDTH-1:0] q0_head;
    logic [STAMP_WIDTH-1:0] q1_head;

    logic                   take0;
    logic                   take1;
    logic [1:0]             status;

    logic                   valid_reg;
    logic                   valid_next;
    logic [1:0]             status_reg;
    logic                   class_reg;
    logic [STAMP_WIDTH-1:0] ostamp_reg;

    assign cmd        = s_tuser[1:0];
    assign item_class = s_tuser[2];
    assign stamp      = s_tdata[STAMP_WIDTH-1:0];

    // Take an item while the result slot is free or draining this cycle
    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Decode the command into pops and pushes; ties between heads go to class 1
    always_comb
    begin
        take0  = 1'b0;
        take1  = 1'b0;
        status = tcfo_pkg::ST_DONE;
        q0_ctrl = '0;
        q1_ctrl = '0;
        unique case (cmd)
            tcfo_pkg::CMD_ENQ:
            begin
                if (item_class ? q1_stat.full : q0_stat.full)
                begin
                    status = tcfo_pkg::ST_FULL;
                end
                else
                begin
                    q0_ctrl.push = accept && !item_class;
                    q1_ctrl.push = accept && item_class;
                end
            end
            tcfo_pkg::CMD_DEQ_ANY:
            begin
                if (q0_stat.empty && q1_stat.empty)
                begin
                    status = tcfo_pkg::ST_EMPTY;
                end
                else if (q1_stat.empty)
                begin
                    take0 = 1'b1;
                end
                else if (q0_stat.empty)
                begin
                    take1 = 1'b1;
                end
                else
                begin
                    take0 = (q0_head < q1_head);
                    take1 = !take0;
                end
            end
            tcfo_pkg::CMD_DEQ_C0:
            begin
                if (q0_stat.empty)
                begin
                    status = tcfo_pkg::ST_EMPTY;
                end
                else
                begin
                    take0 = 1'b1;
                end
            end
            tcfo_pkg::CMD_DEQ_C1:
            begin
                if (q1_stat.empty)
                begin
                    status = tcfo_pkg::ST_EMPTY;
                end
                else
                begin
                    take1 = 1'b1;
                end
            end
            default:
            begin
                status = tcfo_pkg::ST_DONE;
            end
        endcase
        q0_ctrl.pop = accept && take0;
        q1_ctrl.pop = accept && take1;
    end

    tcfo_queue #(.DEPTH(QUEUE_DEPTH), .W(STAMP_WIDTH)) u_q0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (q0_ctrl),
        .push_data (stamp),
        .stat      (q0_stat),
        .head_data (q0_head)
    );

    tcfo_queue #(.DEPTH(QUEUE_DEPTH), .W(STAMP_WIDTH)) u_q1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (q1_ctrl),
        .push_data (stamp),
        .stat      (q1_stat),
        .head_data (q1_head)
    );

    // Result valid: set on accept, drop once the transfer out completes
    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload: stamp and class are zero unless a dequeue removed an item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status;
            class_reg  <= take1;
            ostamp_reg <= take1 ? q1_head : (take0 ? q0_head : '0);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = {class_reg, status_reg};
    assign m_tdata  = TDATA_W'(ostamp_reg);

    a_single_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(q0_ctrl.pop && q1_ctrl.pop))
        else $error("both queues popped");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tuser) && $stable(m_tdata)))
        else $error("result lost under stall");

    a_no_op_without_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> !(q0_ctrl.push || q0_ctrl.pop || q1_ctrl.push || q1_ctrl.pop))
        else $error("queue changed without accept");

endmodule
